>>> src/bmm_pkg.sv
package bmm_pkg;

    localparam int NUM_VARS_DEF   = 16;
    localparam int NUM_VALUES_DEF = 64;

    localparam logic [1:0] CMD_LOAD     = 2'd0;
    localparam logic [1:0] CMD_INIT     = 2'd1;
    localparam logic [1:0] CMD_COMPUTE  = 2'd2;
    localparam logic [1:0] CMD_RESERVED = 2'd3;

    localparam logic REG_VAR_COUNT  = 1'b0;
    localparam logic REG_VALUE_BASE = 1'b1;

    localparam logic [6:0] VAR_COUNT_RESET = 7'd16;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_INIT_START,
        OP_INIT_STEP,
        OP_REPAIR_START,
        OP_REPAIR_STEP,
        OP_ROOT_SKIP,
        OP_SEARCH_START,
        OP_SCAN,
        OP_FETCH,
        OP_FLIP,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        logic k_last;
        logic k_rep_last;
        logic n_zero;
        logic root_matched;
        logic cand_found;
        logic cand_free;
        logic depth_one;
        logic flip_last;
        logic out_free;
    } dp_status_t;

endpackage

>>> src/bmm_ctrl.sv
module bmm_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [1:0]           in_cmd,
    output logic                 in_ready,
    input  bmm_pkg::dp_status_t  status,
    output bmm_pkg::dp_op_t      op
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_INIT   = 8'b00000010,
        S_REPAIR = 8'b00000100,
        S_ROOT   = 8'b00001000,
        S_SCAN   = 8'b00010000,
        S_FETCH  = 8'b00100000,
        S_FLIP   = 8'b01000000,
        S_EMIT   = 8'b10000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op         = bmm_pkg::OP_NONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (in_cmd)
                        bmm_pkg::CMD_LOAD:
                        begin
                            op = bmm_pkg::OP_LOAD;
                        end
                        bmm_pkg::CMD_INIT:
                        begin
                            op = bmm_pkg::OP_INIT_START;
                            if (!status.n_zero)
                            begin
                                state_next = S_INIT;
                            end
                        end
                        bmm_pkg::CMD_COMPUTE:
                        begin
                            op         = bmm_pkg::OP_REPAIR_START;
                            state_next = S_REPAIR;
                        end
                        default:
                        begin
                            op = bmm_pkg::OP_NONE;
                        end
                    endcase
                end
            end
            S_INIT:
            begin
                op = bmm_pkg::OP_INIT_STEP;
                if (status.k_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_REPAIR:
            begin
                op = bmm_pkg::OP_REPAIR_STEP;
                if (status.k_rep_last)
                begin
                    state_next = status.n_zero ? S_IDLE : S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (status.root_matched)
                begin
                    op = bmm_pkg::OP_ROOT_SKIP;
                    if (status.k_last)
                    begin
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    op         = bmm_pkg::OP_SEARCH_START;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                op = bmm_pkg::OP_SCAN;
                if (!status.cand_found)
                begin
                    // pop; an empty stack ends this root's search
                    if (status.depth_one)
                    begin
                        state_next = status.k_last ? S_EMIT : S_ROOT;
                    end
                end
                else if (status.cand_free)
                begin
                    state_next = S_FLIP;
                end
                else
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                op         = bmm_pkg::OP_FETCH;
                state_next = S_SCAN;
            end
            S_FLIP:
            begin
                op = bmm_pkg::OP_FLIP;
                if (status.flip_last)
                begin
                    state_next = status.k_last ? S_EMIT : S_ROOT;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    op = bmm_pkg::OP_EMIT;
                    if (status.k_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> src/bmm_datapath.sv
module bmm_datapath
#(
    parameter int NUM_VARS   = bmm_pkg::NUM_VARS_DEF,
    parameter int NUM_VALUES = bmm_pkg::NUM_VALUES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  bmm_pkg::dp_op_t      op,
    output bmm_pkg::dp_status_t  status,
    input  logic                 cfg_write,
    input  logic                 cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic [5:0]           in_var_index,
    input  logic [63:0]          in_domain_bits,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [5:0]           out_var,
    output logic                 out_matched,
    output logic [31:0]          out_value,
    output logic [6:0]           out_size,
    output logic                 out_last
);

    localparam int VIW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
    localparam int XW  = (NUM_VALUES > 1) ? $clog2(NUM_VALUES) : 1;
    localparam int CW  = $clog2(NUM_VALUES + 1);
    localparam int NW  = $clog2(NUM_VARS + 1);

    logic [6:0]            var_count_reg;
    logic [31:0]           value_base_reg;

    logic [NUM_VALUES-1:0] dom_reg      [NUM_VARS];
    logic [XW-1:0]         v2x_reg      [NUM_VARS];
    logic [NUM_VARS-1:0]   has_reg;
    logic [NUM_VALUES-1:0] taken_reg;
    logic [VIW-1:0]        x2v_mem      [NUM_VALUES];
    logic [VIW-1:0]        w_reg;
    logic [NUM_VARS-1:0]   var_vis_reg;
    logic [NUM_VALUES-1:0] val_vis_reg;
    logic [VIW-1:0]        stk_var_reg  [NUM_VARS];
    logic [CW-1:0]         stk_cur_reg  [NUM_VARS];
    logic [NW-1:0]         depth_reg;
    logic [NW-1:0]         count_reg;
    logic [VIW-1:0]        k_reg;
    logic [VIW-1:0]        fi_reg;

    logic                  out_valid_reg;
    logic [5:0]            out_var_reg;
    logic                  out_matched_reg;
    logic [31:0]           out_value_reg;
    logic [6:0]            out_size_reg;
    logic                  out_last_reg;

    logic [NW-1:0]         n_vars;
    logic                  k_last;
    logic [VIW-1:0]        k_adv;
    logic [VIW-1:0]        top;
    logic [VIW-1:0]        u;
    logic [CW-1:0]         cur;
    logic [NUM_VALUES-1:0] scan_vec;
    logic [NUM_VALUES-1:0] enc_in;
    logic                  found;
    logic [XW-1:0]         sel;
    logic                  drop;
    logic [XW-1:0]         rep_val;
    logic [VIW-1:0]        f_var;
    logic [XW-1:0]         f_val;
    logic                  mem_we;
    logic [XW-1:0]         mem_wa;
    logic [VIW-1:0]        mem_wd;

    assign n_vars  = (var_count_reg > 7'(NUM_VARS)) ? NW'(NUM_VARS) : NW'(var_count_reg);
    assign k_last  = (NW'(k_reg) == (n_vars - NW'(1)));
    assign k_adv   = k_last ? '0 : (k_reg + VIW'(1));
    assign top     = VIW'(depth_reg - NW'(1));
    assign u       = stk_var_reg[top];
    assign cur     = stk_cur_reg[top];
    assign rep_val = v2x_reg[k_reg];
    assign drop    = has_reg[k_reg]
                     && ((NW'(k_reg) >= n_vars) || !dom_reg[k_reg][rep_val]);
    assign f_var   = stk_var_reg[fi_reg];
    assign f_val   = XW'(stk_cur_reg[fi_reg] - CW'(1));

    always_comb
    begin
        for (int j = 0; j < NUM_VALUES; j++)
        begin
            scan_vec[j] = dom_reg[u][j] && !val_vis_reg[j] && (cur <= CW'(j))
                          && !(has_reg[u] && (v2x_reg[u] == XW'(j)));
        end
    end

    assign enc_in = (op == bmm_pkg::OP_INIT_STEP) ? (dom_reg[k_reg] & ~taken_reg) : scan_vec;

    // lowest set bit wins
    always_comb
    begin
        found = 1'b0;
        sel   = '0;
        for (int j = NUM_VALUES - 1; j >= 0; j--)
        begin
            if (enc_in[j])
            begin
                found = 1'b1;
                sel   = XW'(j);
            end
        end
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = sel;
        mem_wd = k_reg;
        if (op == bmm_pkg::OP_INIT_STEP)
        begin
            mem_we = found;
        end
        else if (op == bmm_pkg::OP_FLIP)
        begin
            mem_we = 1'b1;
            mem_wa = f_val;
            mem_wd = f_var;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            x2v_mem[mem_wa] <= mem_wd;
        end
        if (op == bmm_pkg::OP_SCAN)
        begin
            w_reg <= x2v_mem[sel];
        end
    end

    assign status.k_last       = k_last;
    assign status.k_rep_last   = (k_reg == VIW'(NUM_VARS - 1));
    assign status.n_zero       = (n_vars == '0);
    assign status.root_matched = has_reg[k_reg];
    assign status.cand_found   = found;
    assign status.cand_free    = !taken_reg[sel];
    assign status.depth_one    = (depth_reg == NW'(1));
    assign status.flip_last    = (fi_reg == '0);
    assign status.out_free     = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            var_count_reg  <= bmm_pkg::VAR_COUNT_RESET;
            value_base_reg <= '0;
            has_reg        <= '0;
            taken_reg      <= '0;
            var_vis_reg    <= '0;
            val_vis_reg    <= '0;
            depth_reg      <= '0;
            count_reg      <= '0;
            k_reg          <= '0;
            fi_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == bmm_pkg::REG_VAR_COUNT)
                begin
                    var_count_reg <= cfg_data[6:0];
                end
                else
                begin
                    value_base_reg <= cfg_data;
                end
            end
            if (out_valid_reg && out_ready && (op != bmm_pkg::OP_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (op)
                bmm_pkg::OP_NONE:
                begin
                end
                bmm_pkg::OP_LOAD:
                begin
                end
                bmm_pkg::OP_INIT_START:
                begin
                    has_reg   <= '0;
                    taken_reg <= '0;
                    count_reg <= '0;
                    k_reg     <= '0;
                end
                bmm_pkg::OP_INIT_STEP:
                begin
                    if (found)
                    begin
                        v2x_reg[k_reg]  <= sel;
                        has_reg[k_reg]  <= 1'b1;
                        taken_reg[sel]  <= 1'b1;
                        count_reg       <= count_reg + NW'(1);
                    end
                    k_reg <= k_adv;
                end
                bmm_pkg::OP_REPAIR_START:
                begin
                    k_reg <= '0;
                end
                bmm_pkg::OP_REPAIR_STEP:
                begin
                    if (drop)
                    begin
                        has_reg[k_reg]     <= 1'b0;
                        taken_reg[rep_val] <= 1'b0;
                        if (count_reg != '0)
                        begin
                            count_reg <= count_reg - NW'(1);
                        end
                    end
                    k_reg <= status.k_rep_last ? '0 : (k_reg + VIW'(1));
                end
                bmm_pkg::OP_ROOT_SKIP:
                begin
                    k_reg <= k_adv;
                end
                bmm_pkg::OP_SEARCH_START:
                begin
                    var_vis_reg        <= NUM_VARS'(1) << k_reg;
                    val_vis_reg        <= '0;
                    stk_var_reg[0]     <= k_reg;
                    stk_cur_reg[0]     <= '0;
                    depth_reg          <= NW'(1);
                end
                bmm_pkg::OP_SCAN:
                begin
                    if (found)
                    begin
                        val_vis_reg[sel] <= 1'b1;
                        stk_cur_reg[top] <= CW'(sel) + CW'(1);
                        fi_reg           <= top;
                    end
                    else
                    begin
                        depth_reg <= depth_reg - NW'(1);
                        if (depth_reg == NW'(1))
                        begin
                            k_reg <= k_adv;
                        end
                    end
                end
                bmm_pkg::OP_FETCH:
                begin
                    if (!var_vis_reg[w_reg])
                    begin
                        var_vis_reg[w_reg]            <= 1'b1;
                        stk_var_reg[VIW'(depth_reg)]  <= w_reg;
                        stk_cur_reg[VIW'(depth_reg)]  <= '0;
                        depth_reg                     <= depth_reg + NW'(1);
                    end
                end
                bmm_pkg::OP_FLIP:
                begin
                    v2x_reg[f_var]   <= f_val;
                    has_reg[f_var]   <= 1'b1;
                    taken_reg[f_val] <= 1'b1;
                    if (fi_reg == '0)
                    begin
                        count_reg <= count_reg + NW'(1);
                        k_reg     <= k_adv;
                    end
                    else
                    begin
                        fi_reg <= fi_reg - VIW'(1);
                    end
                end
                bmm_pkg::OP_EMIT:
                begin
                    out_valid_reg <= 1'b1;
                    k_reg         <= k_adv;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((op == bmm_pkg::OP_LOAD) && ({1'b0, in_var_index} < 7'(NUM_VARS)))
        begin
            dom_reg[VIW'(in_var_index)] <= in_domain_bits[NUM_VALUES-1:0];
        end
        if (op == bmm_pkg::OP_EMIT)
        begin
            out_var_reg     <= 6'(k_reg);
            out_matched_reg <= has_reg[k_reg];
            out_value_reg   <= has_reg[k_reg] ? (value_base_reg + 32'(v2x_reg[k_reg])) : 32'd0;
            out_size_reg    <= 7'(count_reg);
            out_last_reg    <= k_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_var     = out_var_reg;
    assign out_matched = out_matched_reg;
    assign out_value   = out_value_reg;
    assign out_size    = out_size_reg;
    assign out_last    = out_last_reg;

endmodule

>>> src/bipartite_max_matching_unit.sv
// Maximum bipartite matching between variables and values.
// Input stream s_*: one request per command. s_tuser carries the command
// (load domain, greedy init, compute); s_tdata carries the variable index and
// its domain bitmask. A load writes the domain directly; init starts and then
// visits each variable in use in turn for a greedy match.
// Compute starts, then steps through all NUM_VARS variables to drop stale
// matches, then visits each variable in use to skip it or start its search.
// Each search step scans for a candidate value; a value already taken adds a
// fetch step (value-to-variable memory read), and a found path is flipped one
// frame per step. The total depends on the data and is set by this search
// loop. It then emits one result per variable in use on m_*, one per cycle
// while m_tready stays high, m_tlast on the last one.
// s_tready is high only while idle; a stalled receiver holds the emit loop,
// and the final result may wait in the output register while the next
// request is accepted.
// Configuration writes (cfg_*) are always accepted and take effect at once.
// Reset clears the matching, sets var_count to 16 and value_base to 0;
// domains are undefined until loaded.
module bipartite_max_matching_unit
#(
    parameter int NUM_VARS   = bmm_pkg::NUM_VARS_DEF,
    parameter int NUM_VALUES = bmm_pkg::NUM_VALUES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // var_index[5:0], domain_bits[69:6], zero pad
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // out_var[5:0], matched[6], match_value[38:7],
                                   // match_size[45:39], zero pad
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    bmm_pkg::dp_op_t     op;
    bmm_pkg::dp_status_t status;
    logic [5:0]          out_var;
    logic                out_matched;
    logic [31:0]         out_value;
    logic [6:0]          out_size;

    assign cfg_ready = 1'b1;

    bmm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_cmd   (s_tuser),
        .in_ready (s_tready),
        .status   (status),
        .op       (op)
    );

    bmm_datapath
    #(
        .NUM_VARS   (NUM_VARS),
        .NUM_VALUES (NUM_VALUES)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .op             (op),
        .status         (status),
        .cfg_write      (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_var_index   (s_tdata[5:0]),
        .in_domain_bits (s_tdata[69:6]),
        .out_ready      (m_tready),
        .out_valid      (m_tvalid),
        .out_var        (out_var),
        .out_matched    (out_matched),
        .out_value      (out_value),
        .out_size       (out_size),
        .out_last       (m_tlast)
    );

    assign m_tdata = {2'b00, out_size, out_value, out_matched, out_var};

endmodule

>>> verif/bipartite_max_matching_unit_tb.sv
`timescale 1ns / 100ps

module bipartite_max_matching_unit_tb;

    localparam int NV      = 16;
    localparam int NVAL    = 64;
    localparam int LIMIT   = 3000000;
    localparam int SETTLE  = 60;

    typedef struct {
        logic [5:0]  var_id;
        logic        matched;
        logic [31:0] value;
        logic [6:0]  size;
        logic        last;
    } match_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_data;

    bipartite_max_matching_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [6:0]  var_count;
    logic [31:0] value_base;
    logic [63:0] domains [NV];
    int          var_value [NV];
    bit          var_held [NV];
    int          value_owner [NVAL];
    bit          value_held [NVAL];
    bit          var_seen [NV];
    bit          value_seen [NVAL];
    int          path_var [NV];
    int          path_cur [NV];
    int          match_count;

    match_result_t pending_matches [$];

    int fails;
    int cycles;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("bipartite_max_matching_unit_tb: FAIL");
            $finish;
        end
    end

    // receiver: random back-pressure, or a long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        match_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_matches.size() == 0)
            begin
                $error("unexpected result: out_var %0d", m_tdata[5:0]);
                fails++;
            end
            else
            begin
                want = pending_matches.pop_front();
                if (m_tdata[5:0] !== want.var_id)
                begin
                    $error("out_var: expected %0d, got %0d", want.var_id, m_tdata[5:0]);
                    fails++;
                end
                if (m_tdata[6] !== want.matched)
                begin
                    $error("matched: expected %0d, got %0d", want.matched, m_tdata[6]);
                    fails++;
                end
                if (m_tdata[38:7] !== want.value)
                begin
                    $error("match_value: expected %0d, got %0d",
                           $signed(want.value), $signed(m_tdata[38:7]));
                    fails++;
                end
                if (m_tdata[45:39] !== want.size)
                begin
                    $error("match_size: expected %0d, got %0d", want.size, m_tdata[45:39]);
                    fails++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, m_tlast);
                    fails++;
                end
            end
        end
    end

    function automatic int vars_in_use();
        return (var_count > NV) ? NV : int'(var_count);
    endfunction

    function automatic void bind_pair(int u, int v);
        var_value[u]   = v;
        var_held[u]    = 1'b1;
        value_owner[v] = u;
        value_held[v]  = 1'b1;
    endfunction

    function automatic bit find_augmenting_path(int root);
        int depth;
        int u;
        int cur;
        int v;
        int w;
        bit pushed;
        for (int i = 0; i < NV; i++)
            var_seen[i] = 1'b0;
        for (int i = 0; i < NVAL; i++)
            value_seen[i] = 1'b0;
        var_seen[root] = 1'b1;
        path_var[0] = root;
        path_cur[0] = 0;
        depth = 1;
        while (depth > 0)
        begin
            u = path_var[depth-1];
            cur = path_cur[depth-1];
            pushed = 1'b0;
            while (cur < NVAL)
            begin
                v = cur;
                cur++;
                if (!domains[u][v])
                    continue;
                if (var_held[u] && var_value[u] == v)
                    continue;
                if (value_seen[v])
                    continue;
                value_seen[v] = 1'b1;
                path_cur[depth-1] = cur;
                if (!value_held[v])
                begin
                    // flip the path from the top down
                    for (int k = depth; k > 0; k--)
                        bind_pair(path_var[k-1], path_cur[k-1] - 1);
                    return 1'b1;
                end
                w = value_owner[v];
                if (w >= NV || var_seen[w])
                    continue;
                var_seen[w] = 1'b1;
                if (depth < NV)
                begin
                    path_var[depth] = w;
                    path_cur[depth] = 0;
                    depth++;
                    pushed = 1'b1;
                    break;
                end
            end
            if (!pushed)
                depth--;
        end
        return 1'b0;
    endfunction

    function automatic void predict_matching(logic [1:0] cmd, logic [5:0] idx,
                                             logic [63:0] bits);
        int n;
        match_result_t r;
        n = vars_in_use();
        if (cmd == bmm_pkg::CMD_LOAD)
        begin
            if (idx < NV)
                domains[idx] = bits;
        end
        else if (cmd == bmm_pkg::CMD_INIT)
        begin
            for (int i = 0; i < NV; i++)
                var_held[i] = 1'b0;
            for (int i = 0; i < NVAL; i++)
                value_held[i] = 1'b0;
            match_count = 0;
            for (int k = 0; k < n; k++)
                for (int j = 0; j < NVAL; j++)
                    if (!value_held[j] && domains[k][j])
                    begin
                        bind_pair(k, j);
                        match_count++;
                        break;
                    end
        end
        else if (cmd == bmm_pkg::CMD_COMPUTE)
        begin
            // drop stale matches, including those of variables now out of use
            for (int k = 0; k < NV; k++)
                if (var_held[k] && (k >= n || !domains[k][var_value[k]]))
                begin
                    value_held[var_value[k]] = 1'b0;
                    var_held[k] = 1'b0;
                    if (match_count > 0)
                        match_count--;
                end
            if (match_count < n)
                for (int k = 0; k < n; k++)
                    if (!var_held[k] && find_augmenting_path(k))
                        match_count++;
            for (int k = 0; k < n; k++)
            begin
                r.var_id  = k[5:0];
                r.matched = var_held[k];
                r.value   = var_held[k] ? value_base + 32'(var_value[k]) : 32'd0;
                r.size    = match_count[6:0];
                r.last    = (k + 1 == n);
                pending_matches.push_back(r);
            end
        end
    endfunction

    task automatic send_request(logic [1:0] cmd, logic [5:0] idx, logic [63:0] bits);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, bits, idx};
        do
            @(posedge clk);
        while (!s_tready);
        predict_matching(cmd, idx, bits);
    endtask

    task automatic end_requests();
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        end_requests();
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // only called once the block has drained
    task automatic write_reg(logic idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == bmm_pkg::REG_VAR_COUNT)
            var_count = data[6:0];
        else
            value_base = data;
        @(posedge clk);
    endtask

    function automatic logic [63:0] random_domain();
        logic [63:0] d;
        int span;
        d = {$urandom, $urandom};
        case ($urandom_range(3))
            0: ;
            1: d = d & {$urandom, $urandom};
            default:
            begin
                // narrow window keeps values contended so paths get long
                span = $urandom_range(24, 3);
                d = d & {$urandom, $urandom} & ((64'd1 << span) - 1);
                d = d << $urandom_range(64 - span);
            end
        endcase
        return d;
    endfunction

    task automatic load_all_domains();
        for (int k = 0; k < NV; k++)
            send_request(bmm_pkg::CMD_LOAD, k[5:0], random_domain());
    endtask

    task automatic test_directed();
        send_request(bmm_pkg::CMD_LOAD, 6'd0, 64'd0);
        send_request(bmm_pkg::CMD_LOAD, 6'd1, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(bmm_pkg::CMD_LOAD, 6'd2, 64'd1);
        send_request(bmm_pkg::CMD_LOAD, 6'd3, 64'h8000_0000_0000_0000);
        for (int k = 4; k < NV; k++)
            send_request(bmm_pkg::CMD_LOAD, k[5:0], 64'h3 << k);
        // out-of-range loads and an unknown command are ignored
        send_request(bmm_pkg::CMD_LOAD, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(bmm_pkg::CMD_LOAD, 6'd16, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(bmm_pkg::CMD_RESERVED, 6'h2A, 64'hAAAA_5555_AAAA_5555);
        send_request(bmm_pkg::CMD_INIT, 6'd0, 64'd0);
        send_request(bmm_pkg::CMD_COMPUTE, 6'h3F, 64'hFFFF_FFFF_FFFF_FFFF);
        // shrink a domain so that a held value leaves it
        send_request(bmm_pkg::CMD_LOAD, 6'd1, 64'h0000_0000_0000_000E);
        send_request(bmm_pkg::CMD_COMPUTE, 6'd0, 64'd0);
        drain();
        write_reg(bmm_pkg::REG_VALUE_BASE, 32'h7FFF_FFFF);
        write_reg(bmm_pkg::REG_VAR_COUNT, 32'd0);
        send_request(bmm_pkg::CMD_COMPUTE, 6'd0, 64'd0);
        drain();
        write_reg(bmm_pkg::REG_VAR_COUNT, 32'd64);
        send_request(bmm_pkg::CMD_COMPUTE, 6'd0, 64'd0);
        drain();
        write_reg(bmm_pkg::REG_VAR_COUNT, 32'h7F);
        write_reg(bmm_pkg::REG_VALUE_BASE, 32'h8000_0000);
        send_request(bmm_pkg::CMD_INIT, 6'd0, 64'd0);
        send_request(bmm_pkg::CMD_COMPUTE, 6'd0, 64'd0);
        drain();
        // dropping variables out of use releases their values
        write_reg(bmm_pkg::REG_VAR_COUNT, 32'd1);
        write_reg(bmm_pkg::REG_VALUE_BASE, 32'hFFFF_FFFF);
        send_request(bmm_pkg::CMD_COMPUTE, 6'd0, 64'd0);
        drain();
    endtask

    task automatic random_phase(int items);
        int sent;
        int pick;
        sent = 0;
        while (sent < items)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                send_request(bmm_pkg::CMD_INIT, 6'($urandom), {$urandom, $urandom});
            else if (pick < 22)
                send_request(bmm_pkg::CMD_COMPUTE, 6'($urandom), {$urandom, $urandom});
            else if (pick < 26)
                send_request(bmm_pkg::CMD_RESERVED, 6'($urandom), {$urandom, $urandom});
            else if (pick < 30)
                send_request(bmm_pkg::CMD_LOAD, 6'($urandom_range(63, NV)),
                             {$urandom, $urandom});
            else
                send_request(bmm_pkg::CMD_LOAD, 6'($urandom_range(NV - 1)), random_domain());
            sent++;
        end
        send_request(bmm_pkg::CMD_COMPUTE, 6'd0, 64'd0);
        drain();
    endtask

    task automatic test_random();
        int modes [3][2];
        modes = '{'{30, 53}, '{53, 30}, '{0, 0}};
        for (int m = 0; m < 3; m++)
        begin
            send_idle_pct = modes[m][0];
            recv_idle_pct = modes[m][1];
            for (int p = 0; p < 2; p++)
            begin
                write_reg(bmm_pkg::REG_VAR_COUNT, ($urandom_range(4) == 0)
                          ? 32'($urandom_range(127, 17)) | ({$urandom} & 32'hFFFF_FF80)
                          : 32'($urandom_range(16, 1)));
                write_reg(bmm_pkg::REG_VALUE_BASE, $urandom);
                load_all_domains();
                send_request(bmm_pkg::CMD_INIT, 6'd0, 64'd0);
                random_phase(7);
            end
        end
        write_reg(bmm_pkg::REG_VAR_COUNT, 32'd16);
    endtask

    task automatic test_pressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left = 500;
        send_request(bmm_pkg::CMD_COMPUTE, 6'd0, 64'd0);
        send_request(bmm_pkg::CMD_LOAD, 6'd5, random_domain());
        send_request(bmm_pkg::CMD_COMPUTE, 6'd0, 64'd0);
        end_requests();
        // pause until every result is back
        while (pending_matches.size() != 0)
            @(posedge clk);
        send_request(bmm_pkg::CMD_COMPUTE, 6'd0, 64'd0);
        drain();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= bmm_pkg::CMD_LOAD;
        m_tready <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= bmm_pkg::REG_VAR_COUNT;
        cfg_data <= '0;
        fails = 0;
        cycles = 0;
        hold_left = 0;
        send_idle_pct = 30;
        recv_idle_pct = 53;
        var_count = bmm_pkg::VAR_COUNT_RESET;
        value_base = 32'd0;
        match_count = 0;
        for (int i = 0; i < NV; i++)
        begin
            domains[i] = '0;
            var_held[i] = 1'b0;
            var_value[i] = 0;
        end
        for (int i = 0; i < NVAL; i++)
        begin
            value_held[i] = 1'b0;
            value_owner[i] = 0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random();
        test_pressure();

        if (fails == 0)
            $display("bipartite_max_matching_unit_tb: PASS");
        else
            $display("bipartite_max_matching_unit_tb: FAIL");
        $finish;
    end

endmodule
